/* rtl/core/pidaw_pkg.sv */
// Shared types and constants for the PID controller with anti-windup.
// Holds field widths, payload structs, register indexes and sequencer states.
// No dependencies.
`default_nettype none

package pidaw_pkg;

    // Field widths of the transfer payloads and of the integral
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int INTEG_W   = 48;
    // Intermediate increments and rates saturate to this width
    localparam int WIDE_W    = 64;
    // Working width for signed sums of wide values
    localparam int WORK_W    = WIDE_W + 2;
    localparam int CFG_IDX_W = 3;

    // Input op codes
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Reset values of the output limits
    localparam logic signed [DATA_W-1:0] LIMIT_LOW_RST  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] LIMIT_HIGH_RST = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P     = 3'd0,
        CFG_GAIN_I     = 3'd1,
        CFG_GAIN_D     = 3'd2,
        CFG_LIMIT_LOW  = 3'd3,
        CFG_LIMIT_HIGH = 3'd4,
        CFG_TARGET     = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
        logic signed [DATA_W-1:0] limit_low;
        logic signed [DATA_W-1:0] limit_high;
        logic signed [DATA_W-1:0] target;
    } cfg_t;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] measured;
        logic        [DATA_W-1:0] step_time;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  p_part;
        logic signed [DATA_W-1:0]  i_part;
        logic signed [DATA_W-1:0]  d_part;
        logic signed [DATA_W-1:0]  drive;
        logic                      clipped;
        logic signed [INTEG_W-1:0] integral_now;
    } out_t;

    // Request to the shared multiply/divide unit
    typedef struct packed {
        logic start;
        logic div;
    } alu_req_t;

    // Sequencer status toward the channel logic
    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P,
        ST_INC,
        ST_I,
        ST_RATE,
        ST_D,
        ST_PRE,
        ST_IOLD,
        ST_LIM,
        ST_ICLAMP,
        ST_SUM,
        ST_CORR,
        ST_COMMIT,
        ST_DONE
    } seq_state_t;

endpackage

`default_nettype wire

/* rtl/core/pidaw_alu.sv */
// Shared iterative arithmetic unit: shift-add multiply and restoring divide
// on unsigned magnitudes, one bit per cycle. Uses pidaw_pkg.
`default_nettype none

module pidaw_alu #(
    parameter int FRAC_BITS = pidaw_pkg::FRAC_W,
    parameter int A_W       = pidaw_pkg::WIDE_W,
    parameter int B_W       = pidaw_pkg::DATA_W + 3
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire pidaw_pkg::alu_req_t     req,
    input  wire logic [A_W-1:0]          opa,
    input  wire logic [B_W-1:0]          opb,
    output logic                         done,
    output logic [A_W+B_W-1:0]           res
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(A_W);

    logic             busy_reg;
    logic             done_reg;
    logic             div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [A_W-1:0]   quo_reg;
    logic [B_W-1:0]   dvs_reg;
    logic [B_W-1:0]   rem_reg;
    logic [P_W-1:0]   prod_reg;

    logic [A_W:0]     hi_sum;
    logic [B_W:0]     trial;
    logic [B_W:0]     diff;
    logic             ge;

    // Multiply step: add the multiplicand into the upper half when the low bit is set
    assign hi_sum = prod_reg[0] ? {1'b0, prod_reg[P_W-1:B_W]} + {1'b0, quo_reg}
                                : {1'b0, prod_reg[P_W-1:B_W]};

    // Divide step: shift in the next numerator bit and try to subtract
    assign trial = {rem_reg, quo_reg[A_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    // Control: busy flag, step counter and completion pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.div ? CNT_W'(A_W - 1) : CNT_W'(B_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    // Datapath: load operands, then advance one bit a cycle
    always_ff @(posedge aclk) begin
        if (req.start) begin
            div_reg  <= req.div;
            quo_reg  <= opa;
            dvs_reg  <= opb;
            rem_reg  <= '0;
            prod_reg <= P_W'(opb);
        end else if (busy_reg) begin
            if (div_reg) begin
                rem_reg <= ge ? diff[B_W-1:0] : trial[B_W-1:0];
                quo_reg <= {quo_reg[A_W-2:0], ge};
            end else begin
                prod_reg <= {hi_sum, prod_reg[B_W-1:1]};
            end
        end
    end

    assign done = done_reg;
    assign res  = div_reg ? P_W'(quo_reg) : (prod_reg >> FRAC_BITS);

endmodule

`default_nettype wire

/* rtl/core/pidaw_seq.sv */
// Step sequencer: controller state, term registers and the order of
// operations on the shared arithmetic unit. Uses pidaw_pkg.
`default_nettype none

module pidaw_seq #(
    parameter int FRAC_BITS = pidaw_pkg::FRAC_W,
    parameter int A_W       = pidaw_pkg::WIDE_W,
    parameter int B_W       = pidaw_pkg::DATA_W + 3
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire pidaw_pkg::in_t          item,
    input  wire pidaw_pkg::cfg_t         cfg,
    input  wire logic                    take,
    output pidaw_pkg::seq_stat_t         stat,
    output pidaw_pkg::out_t              result,
    output pidaw_pkg::alu_req_t          alu_req,
    output logic [A_W-1:0]               alu_a,
    output logic [B_W-1:0]               alu_b,
    input  wire logic                    alu_done,
    input  wire logic [A_W+B_W-1:0]      alu_res
);

    localparam int D   = pidaw_pkg::DATA_W;
    localparam int IW  = pidaw_pkg::INTEG_W;
    localparam int XW  = pidaw_pkg::WORK_W;
    localparam int WW  = pidaw_pkg::WIDE_W;
    localparam int P_W = A_W + B_W;

    localparam logic signed [XW-1:0] INT_HI = {{(XW-IW+1){1'b0}}, {(IW-1){1'b1}}};
    localparam logic signed [XW-1:0] INT_LO = {{(XW-IW+1){1'b1}}, {(IW-1){1'b0}}};
    localparam logic signed [XW-1:0] ONE_X  = XW'(1);

    // Saturate a magnitude with a sign to a signed width
    function automatic logic signed [XW-1:0] sat_mag(input logic neg,
                                                     input logic [P_W-1:0] m,
                                                     input logic [6:0] w);
        logic [P_W-1:0]        top;
        logic [P_W-1:0]        lim;
        logic signed [XW-1:0]  big;
        logic signed [XW-1:0]  mv;
        top = P_W'(1) << (w - 7'd1);
        lim = neg ? top : top - P_W'(1);
        big = $signed(top[XW-1:0]);
        mv  = $signed(m[XW-1:0]);
        if (m > lim) begin
            sat_mag = neg ? -big : big - ONE_X;
        end else begin
            sat_mag = neg ? -mv : mv;
        end
    endfunction

    // Clamp a working value to the integral width
    function automatic logic signed [IW-1:0] clamp_int(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] y;
        y = x;
        if (x > INT_HI) begin
            y = INT_HI;
        end else if (x < INT_LO) begin
            y = INT_LO;
        end
        clamp_int = y[IW-1:0];
    endfunction

    pidaw_pkg::seq_state_t state_reg, state_next;

    logic                     issued_reg;
    logic signed [IW-1:0]     integ_reg;
    logic signed [D-1:0]      last_meas_reg;
    logic                     first_reg;

    pidaw_pkg::in_t           item_reg;
    pidaw_pkg::out_t          res_reg;
    logic signed [D:0]        err_reg;
    logic signed [D-1:0]      p_reg;
    logic signed [D-1:0]      i_reg;
    logic signed [D-1:0]      d_reg;
    logic signed [IW-1:0]     acc_reg;
    logic signed [WW-1:0]     rate_reg;

    logic                     alu_on;
    logic                     alu_neg;
    logic [6:0]               sat_w;
    logic signed [XW-1:0]     sat_val;

    logic [D:0]               err_mag;
    logic [D-1:0]             gp_mag;
    logic [D-1:0]             gi_mag;
    logic [D-1:0]             gd_mag;
    logic [IW-1:0]            acc_mag;
    logic [WW-1:0]            rate_mag;
    logic signed [D:0]        delta;
    logic [D:0]               delta_mag;
    logic [D-1:0]             ll_mag;
    logic [D-1:0]             lh_mag;
    logic [D+1:0]             m4;
    logic [B_W-1:0]           gi5;
    logic [B_W-1:0]           gi2;
    logic                     gi_nz;
    logic                     gd_pos;

    logic signed [D+1:0]      sum_c;
    logic signed [D+1:0]      ll_x;
    logic signed [D+1:0]      lh_x;
    logic signed [D+1:0]      lo_c;
    logic signed [D+1:0]      drv_c;
    logic                     clip_c;
    logic signed [D+2:0]      ex_c;
    logic [D+2:0]             ex_mag;
    logic                     revert_c;
    logic signed [IW-1:0]     lim_v;
    logic                     over_c;
    logic                     under_c;

    // Magnitudes and derived operands
    assign err_mag   = err_reg[D] ? $unsigned(-err_reg) : $unsigned(err_reg);
    assign gp_mag    = cfg.gain_p[D-1] ? $unsigned(-cfg.gain_p) : $unsigned(cfg.gain_p);
    assign gi_mag    = cfg.gain_i[D-1] ? $unsigned(-cfg.gain_i) : $unsigned(cfg.gain_i);
    assign gd_mag    = cfg.gain_d[D-1] ? $unsigned(-cfg.gain_d) : $unsigned(cfg.gain_d);
    assign acc_mag   = acc_reg[IW-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
    assign rate_mag  = rate_reg[WW-1] ? $unsigned(-rate_reg) : $unsigned(rate_reg);
    assign delta     = (D+1)'(item_reg.measured) - (D+1)'(last_meas_reg);
    assign delta_mag = delta[D] ? $unsigned(-delta) : $unsigned(delta);
    assign ll_mag    = cfg.limit_low[D-1] ? $unsigned(-cfg.limit_low)
                                          : $unsigned(cfg.limit_low);
    assign lh_mag    = cfg.limit_high[D-1] ? $unsigned(-cfg.limit_high)
                                           : $unsigned(cfg.limit_high);
    assign m4        = {((ll_mag > lh_mag) ? ll_mag : lh_mag), 2'b00};
    assign gi5       = (B_W'(gi_mag) << 2) + B_W'(gi_mag);
    assign gi2       = B_W'(gi_mag) << 1;
    assign gi_nz     = (cfg.gain_i != '0);
    assign gd_pos    = !cfg.gain_d[D-1] && (cfg.gain_d != '0);

    // Sum of terms, output clamp and excess
    assign sum_c   = (D+2)'(p_reg) + (D+2)'(i_reg) + (D+2)'(d_reg);
    assign ll_x    = (D+2)'(cfg.limit_low);
    assign lh_x    = (D+2)'(cfg.limit_high);
    assign lo_c    = (sum_c < ll_x) ? ll_x : sum_c;
    assign drv_c   = (lo_c > lh_x) ? lh_x : lo_c;
    assign clip_c  = (drv_c != sum_c);
    assign ex_c    = (D+3)'(sum_c) - (D+3)'(drv_c);
    assign ex_mag  = ex_c[D+2] ? $unsigned(-ex_c) : $unsigned(ex_c);

    // Stop integrating when the output is past a limit and the error pushes further
    assign revert_c = ((sum_c > lh_x) && !err_reg[D] && (err_reg != '0))
                   || ((sum_c < ll_x) && err_reg[D]);

    assign sat_val = sat_mag(alu_neg, alu_res, sat_w);
    assign lim_v   = sat_val[IW-1:0];
    assign over_c  = (acc_reg > lim_v);
    assign under_c = (acc_reg < -lim_v);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pidaw_pkg::ST_IDLE: begin
                if (start) begin
                    if (item.op == pidaw_pkg::OP_CLEAR || item.step_time == '0) begin
                        state_next = pidaw_pkg::ST_DONE;
                    end else begin
                        state_next = pidaw_pkg::ST_P;
                    end
                end
            end
            pidaw_pkg::ST_P:    if (alu_done) state_next = pidaw_pkg::ST_INC;
            pidaw_pkg::ST_INC:  if (alu_done) state_next = pidaw_pkg::ST_I;
            pidaw_pkg::ST_I: begin
                if (alu_done) begin
                    state_next = first_reg ? pidaw_pkg::ST_PRE : pidaw_pkg::ST_RATE;
                end
            end
            pidaw_pkg::ST_RATE: if (alu_done) state_next = pidaw_pkg::ST_D;
            pidaw_pkg::ST_D:    if (alu_done) state_next = pidaw_pkg::ST_PRE;
            pidaw_pkg::ST_PRE: begin
                if (revert_c) begin
                    state_next = pidaw_pkg::ST_IOLD;
                end else begin
                    state_next = gi_nz ? pidaw_pkg::ST_LIM : pidaw_pkg::ST_SUM;
                end
            end
            pidaw_pkg::ST_IOLD: begin
                if (alu_done) begin
                    state_next = gi_nz ? pidaw_pkg::ST_LIM : pidaw_pkg::ST_SUM;
                end
            end
            pidaw_pkg::ST_LIM: begin
                if (alu_done) begin
                    state_next = (over_c || under_c) ? pidaw_pkg::ST_ICLAMP
                                                     : pidaw_pkg::ST_SUM;
                end
            end
            pidaw_pkg::ST_ICLAMP: if (alu_done) state_next = pidaw_pkg::ST_SUM;
            pidaw_pkg::ST_SUM: begin
                state_next = (clip_c && gi_nz) ? pidaw_pkg::ST_CORR : pidaw_pkg::ST_COMMIT;
            end
            pidaw_pkg::ST_CORR: if (alu_done) state_next = pidaw_pkg::ST_COMMIT;
            pidaw_pkg::ST_COMMIT: state_next = pidaw_pkg::ST_DONE;
            pidaw_pkg::ST_DONE:   if (take) state_next = pidaw_pkg::ST_IDLE;
            default:              state_next = pidaw_pkg::ST_IDLE;
        endcase
    end

    // Operand selection for the shared unit
    always_comb begin
        alu_on  = 1'b0;
        alu_req = '0;
        alu_a   = '0;
        alu_b   = '0;
        alu_neg = 1'b0;
        sat_w   = 7'(D);
        unique case (state_reg)
            pidaw_pkg::ST_P: begin
                alu_on  = 1'b1;
                alu_a   = A_W'(err_mag);
                alu_b   = B_W'(gp_mag);
                alu_neg = err_reg[D] ^ cfg.gain_p[D-1];
            end
            pidaw_pkg::ST_INC: begin
                alu_on  = 1'b1;
                alu_a   = A_W'(err_mag);
                alu_b   = B_W'(item_reg.step_time);
                alu_neg = err_reg[D];
                sat_w   = 7'(WW);
            end
            pidaw_pkg::ST_I, pidaw_pkg::ST_IOLD, pidaw_pkg::ST_ICLAMP: begin
                alu_on  = 1'b1;
                alu_a   = A_W'(acc_mag);
                alu_b   = B_W'(gi_mag);
                alu_neg = acc_reg[IW-1] ^ cfg.gain_i[D-1];
            end
            pidaw_pkg::ST_RATE: begin
                alu_on      = 1'b1;
                alu_req.div = 1'b1;
                alu_a       = A_W'(delta_mag) << FRAC_BITS;
                alu_b       = B_W'(item_reg.step_time);
                alu_neg     = delta[D];
                sat_w       = 7'(WW);
            end
            pidaw_pkg::ST_D: begin
                alu_on  = 1'b1;
                alu_a   = A_W'(rate_mag);
                alu_b   = B_W'(gd_mag);
                alu_neg = gd_pos ^ rate_reg[WW-1];
            end
            pidaw_pkg::ST_LIM: begin
                alu_on      = 1'b1;
                alu_req.div = 1'b1;
                alu_a       = A_W'(m4) << FRAC_BITS;
                alu_b       = gi5;
                sat_w       = 7'(IW);
            end
            pidaw_pkg::ST_CORR: begin
                alu_on      = 1'b1;
                alu_req.div = 1'b1;
                alu_a       = A_W'(ex_mag) << FRAC_BITS;
                alu_b       = gi2;
                alu_neg     = ex_c[D+2] ^ cfg.gain_i[D-1];
                sat_w       = 7'(WW - 1);
            end
            default: begin
                alu_on = 1'b0;
            end
        endcase
        alu_req.start = alu_on && !issued_reg;
    end

    // Control state and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pidaw_pkg::ST_IDLE;
            issued_reg    <= 1'b0;
            integ_reg     <= '0;
            last_meas_reg <= '0;
            first_reg     <= 1'b1;
        end else begin
            state_reg <= state_next;
            if (alu_req.start) begin
                issued_reg <= 1'b1;
            end else if (alu_done) begin
                issued_reg <= 1'b0;
            end
            if (state_reg == pidaw_pkg::ST_IDLE && start && item.op == pidaw_pkg::OP_CLEAR) begin
                integ_reg <= '0;
                first_reg <= 1'b1;
            end else if (state_reg == pidaw_pkg::ST_COMMIT) begin
                integ_reg     <= acc_reg;
                first_reg     <= 1'b0;
                last_meas_reg <= item_reg.measured;
            end
        end
    end

    // Working registers: capture each result of the shared unit
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            pidaw_pkg::ST_IDLE: begin
                if (start) begin
                    item_reg <= item;
                    err_reg  <= (D+1)'(cfg.target) - (D+1)'(item.measured);
                    p_reg    <= '0;
                    i_reg    <= '0;
                    d_reg    <= '0;
                    // Clear op reports zero, a zero step time the held integral
                    res_reg  <= '{p_part: '0, i_part: '0, d_part: '0,
                                  drive: '0, clipped: 1'b0,
                                  integral_now: (item.op == pidaw_pkg::OP_CLEAR)
                                                ? IW'(0) : integ_reg};
                end
            end
            pidaw_pkg::ST_P: if (alu_done) p_reg <= sat_val[D-1:0];
            pidaw_pkg::ST_INC: begin
                if (alu_done) acc_reg <= clamp_int(XW'(integ_reg) + sat_val);
            end
            pidaw_pkg::ST_I, pidaw_pkg::ST_IOLD, pidaw_pkg::ST_ICLAMP: begin
                if (alu_done) i_reg <= sat_val[D-1:0];
            end
            pidaw_pkg::ST_RATE: if (alu_done) rate_reg <= sat_val[WW-1:0];
            pidaw_pkg::ST_D:    if (alu_done) d_reg <= sat_val[D-1:0];
            pidaw_pkg::ST_PRE:  if (revert_c) acc_reg <= integ_reg;
            pidaw_pkg::ST_LIM: begin
                if (alu_done) begin
                    if (over_c) begin
                        acc_reg <= lim_v;
                    end else if (under_c) begin
                        acc_reg <= -lim_v;
                    end
                end
            end
            pidaw_pkg::ST_CORR: begin
                if (alu_done) acc_reg <= clamp_int(XW'(acc_reg) - sat_val);
            end
            pidaw_pkg::ST_COMMIT: begin
                res_reg <= '{p_part: p_reg, i_part: i_reg, d_part: d_reg,
                             drive: drv_c[D-1:0], clipped: clip_c,
                             integral_now: acc_reg};
            end
            default: begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign stat.idle = (state_reg == pidaw_pkg::ST_IDLE);
    assign stat.done = (state_reg == pidaw_pkg::ST_DONE);
    assign result    = res_reg;

    // A completion from the shared unit always answers a request of ours
    ap_done_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> issued_reg)
        else $error("arithmetic unit finished without a pending request");

    // Integral only changes on a clear op or at commit
    ap_integ_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != pidaw_pkg::ST_IDLE && state_reg != pidaw_pkg::ST_COMMIT)
        |=> $stable(integ_reg))
        else $error("integral changed in the middle of a step");

    // First-sample flag only changes on a clear op or at commit
    ap_first_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != pidaw_pkg::ST_IDLE && state_reg != pidaw_pkg::ST_COMMIT)
        |=> $stable(first_reg))
        else $error("first-sample flag changed in the middle of a step");

endmodule

`default_nettype wire

/* rtl/core/pid_antiwindup_controller.sv */
// PID controller with derivative on measurement and anti-windup, top level.
// Depends on pidaw_pkg, pidaw_alu and pidaw_seq.
//
// One item is worked at a time. A clear op or a zero step time finishes
// without the arithmetic unit. A control step runs every multiply and divide
// through one shared bit-serial unit: a multiply steps through 35 operand
// bits, a divide through 64 quotient bits. A step costs three multiplies
// plus the derivative's divide and multiply after the first sample, one more
// multiply each when integration is undone and when the integral bound bites,
// a divide for the bound when the integral gain is nonzero, and a divide for
// back-calculation when the output is also clipped. The input is ready again
// once the result sits in the output register, even while it waits to be taken.
`default_nettype none

module pid_antiwindup_controller #(
    parameter int FRAC_BITS = pidaw_pkg::FRAC_W
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [pidaw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pidaw_pkg::DATA_W-1:0]        cfg_wr_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire pidaw_pkg::in_t                      s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output pidaw_pkg::out_t                          m_data
);

    localparam int A_W = (pidaw_pkg::DATA_W + FRAC_BITS + 2 > pidaw_pkg::WIDE_W)
                       ? pidaw_pkg::DATA_W + FRAC_BITS + 2 : pidaw_pkg::WIDE_W;
    localparam int B_W = pidaw_pkg::DATA_W + 3;

    pidaw_pkg::cfg_t      cfg_reg;
    pidaw_pkg::seq_stat_t stat;
    pidaw_pkg::out_t      seq_res;
    pidaw_pkg::out_t      m_data_reg;
    pidaw_pkg::alu_req_t  alu_req;
    logic                 m_valid_reg;
    logic [A_W-1:0]       alu_a;
    logic [B_W-1:0]       alu_b;
    logic                 alu_done;
    logic [A_W+B_W-1:0]   alu_res;
    logic                 start;
    logic                 take;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{gain_p: '0, gain_i: '0, gain_d: '0,
                         limit_low: pidaw_pkg::LIMIT_LOW_RST,
                         limit_high: pidaw_pkg::LIMIT_HIGH_RST,
                         target: '0};
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pidaw_pkg::CFG_GAIN_P:     cfg_reg.gain_p     <= cfg_wr_data;
                pidaw_pkg::CFG_GAIN_I:     cfg_reg.gain_i     <= cfg_wr_data;
                pidaw_pkg::CFG_GAIN_D:     cfg_reg.gain_d     <= cfg_wr_data;
                pidaw_pkg::CFG_LIMIT_LOW:  cfg_reg.limit_low  <= cfg_wr_data;
                pidaw_pkg::CFG_LIMIT_HIGH: cfg_reg.limit_high <= cfg_wr_data;
                pidaw_pkg::CFG_TARGET:     cfg_reg.target     <= cfg_wr_data;
                default:                   cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign s_ready = stat.idle;
    assign start   = s_valid && s_ready;
    // Move a finished result into the output register once it is free
    assign take    = stat.done && (!m_valid_reg || m_ready);

    pidaw_seq #(
        .FRAC_BITS (FRAC_BITS),
        .A_W       (A_W),
        .B_W       (B_W)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .item     (s_data),
        .cfg      (cfg_reg),
        .take     (take),
        .stat     (stat),
        .result   (seq_res),
        .alu_req  (alu_req),
        .alu_a    (alu_a),
        .alu_b    (alu_b),
        .alu_done (alu_done),
        .alu_res  (alu_res)
    );

    pidaw_alu #(
        .FRAC_BITS (FRAC_BITS),
        .A_W       (A_W),
        .B_W       (B_W)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (alu_a),
        .opb     (alu_b),
        .done    (alu_done),
        .res     (alu_res)
    );

    // Output register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (take) begin
            m_data_reg <= seq_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking bench for pid_antiwindup_controller: random and directed PID steps.
// Holds an internal fixed-point predictor and compares every result transfer.
// Depends on pidaw_pkg and the RTL of the controller.
`default_nettype none

module testbench;

    localparam int    LIMIT_CYCLES = 10000000;
    localparam int    SETTLE_CYCLES = 500;
    localparam logic [pidaw_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [pidaw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [pidaw_pkg::DATA_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    pidaw_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pidaw_pkg::out_t m_data;

    pid_antiwindup_controller dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    // Stimulus and expected results
    pidaw_pkg::in_t  step_queue[$];
    pidaw_pkg::out_t expected_results[$];
    int   fail_count = 0;
    int   sent_count = 0;
    int   got_count = 0;
    int   clip_count = 0;
    bit   calm = 1'b0;
    int   cycle_count = 0;

    // Controller model: configuration and state
    longint kp, ki, kd, lim_lo, lim_hi, setpoint;
    longint integ, prev_meas;
    bit     first_pt, clip_st;

    function automatic logic [63:0] magnitude(longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    // Saturate a magnitude with sign to a signed w-bit value
    function automatic longint sat_from_mag(bit neg, logic [127:0] m, int w);
        logic [127:0] lim;
        lim = (128'd1 << (w - 1)) - (neg ? 128'd0 : 128'd1);
        if (m > lim) m = lim;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint fx_mul(longint a, longint b, int w);
        logic [127:0] prod;
        prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        return sat_from_mag((a < 0) != (b < 0), prod >> pidaw_pkg::FRAC_W, w);
    endfunction

    function automatic longint fx_div(bit neg, logic [63:0] n, logic [63:0] d, int w);
        logic [127:0] q;
        q = ({64'd0, n} << pidaw_pkg::FRAC_W) / {64'd0, d};
        return sat_from_mag(neg, q, w);
    endfunction

    function automatic longint sat_sum(longint a, longint b, int w);
        logic signed [65:0] s, hi;
        s = a;
        s = s + b;
        hi = (66'sd1 <<< (w - 1)) - 66'sd1;
        if (s > hi) s = hi;
        if (s < -hi - 66'sd1) s = -hi - 66'sd1;
        return longint'(s);
    endfunction

    // Advance the model by one accepted item and return its result
    function automatic pidaw_pkg::out_t pid_predict(pidaw_pkg::in_t it);
        pidaw_pkg::out_t r;
        longint meas, err, p, i, d, old, pre, sum, drv, bound, ex, corr, delta, rate;
        logic [63:0] dt, m;
        r = '0;
        if (it.op == pidaw_pkg::OP_CLEAR) begin
            integ = 0;
            first_pt = 1'b1;
            clip_st = 1'b0;
            return r;
        end
        meas = it.measured;
        dt = {32'd0, it.step_time};
        if (dt == 0) begin
            r.integral_now = integ[pidaw_pkg::INTEG_W-1:0];
            return r;
        end
        err = setpoint - meas;
        p = fx_mul(kp, err, pidaw_pkg::DATA_W);
        old = integ;
        integ = sat_sum(old, fx_mul(err, longint'(dt), 64), pidaw_pkg::INTEG_W);
        i = fx_mul(ki, integ, pidaw_pkg::DATA_W);
        d = 0;
        if (!first_pt) begin
            delta = meas - prev_meas;
            rate = fx_div(delta < 0, magnitude(delta), dt, 64);
            d = fx_mul(-kd, rate, pidaw_pkg::DATA_W);
        end
        // Undo integration when the output is already past a limit and the error pushes further
        pre = p + i + d;
        if ((pre > lim_hi && err > 0) || (pre < lim_lo && err < 0)) begin
            integ = old;
            i = fx_mul(ki, integ, pidaw_pkg::DATA_W);
        end
        if (ki != 0) begin
            m = magnitude(lim_lo) > magnitude(lim_hi) ? magnitude(lim_lo) : magnitude(lim_hi);
            bound = fx_div(1'b0, m * 4, 5 * magnitude(ki), pidaw_pkg::INTEG_W);
            if (integ > bound) integ = bound;
            if (integ < -bound) integ = -bound;
            i = fx_mul(ki, integ, pidaw_pkg::DATA_W);
        end
        first_pt = 1'b0;
        prev_meas = meas;
        sum = p + i + d;
        drv = sum < lim_lo ? lim_lo : sum;
        drv = drv > lim_hi ? lim_hi : drv;
        clip_st = (drv != sum);
        // Back-calculate the integral by half the excess divided by the integral gain
        if (clip_st && ki != 0) begin
            ex = sum - drv;
            corr = fx_div((ex < 0) != (ki < 0), magnitude(ex), 2 * magnitude(ki), 63);
            integ = sat_sum(integ, -corr, pidaw_pkg::INTEG_W);
        end
        r.p_part = p[pidaw_pkg::DATA_W-1:0];
        r.i_part = i[pidaw_pkg::DATA_W-1:0];
        r.d_part = d[pidaw_pkg::DATA_W-1:0];
        r.drive = drv[pidaw_pkg::DATA_W-1:0];
        r.clipped = clip_st;
        r.integral_now = integ[pidaw_pkg::INTEG_W-1:0];
        return r;
    endfunction

    // Input driver with random gap bursts
    int send_gap = 0;
    always @(posedge aclk) begin
        logic nv;
        nv = s_valid;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(pid_predict(s_data));
                sent_count++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (step_queue.size() != 0 && !calm && $urandom_range(9) == 0) begin
                    send_gap = $urandom_range(16);
                end else if (step_queue.size() != 0) begin
                    s_data <= step_queue.pop_front();
                    nv = 1'b1;
                end
            end
            s_valid <= nv;
        end
    end

    // Result monitor with random stall bursts
    int hold_gap = 0;
    always @(posedge aclk) begin
        pidaw_pkg::out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got_count++;
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.clipped) clip_count++;
                    if (m_data.p_part !== want.p_part) begin
                        $error("p_part exp %0d got %0d", want.p_part, m_data.p_part);
                        fail_count++;
                    end
                    if (m_data.i_part !== want.i_part) begin
                        $error("i_part exp %0d got %0d", want.i_part, m_data.i_part);
                        fail_count++;
                    end
                    if (m_data.d_part !== want.d_part) begin
                        $error("d_part exp %0d got %0d", want.d_part, m_data.d_part);
                        fail_count++;
                    end
                    if (m_data.drive !== want.drive) begin
                        $error("drive exp %0d got %0d", want.drive, m_data.drive);
                        fail_count++;
                    end
                    if (m_data.clipped !== want.clipped) begin
                        $error("clipped exp %0d got %0d", want.clipped, m_data.clipped);
                        fail_count++;
                    end
                    if (m_data.integral_now !== want.integral_now) begin
                        $error("integral_now exp %0d got %0d",
                               want.integral_now, m_data.integral_now);
                        fail_count++;
                    end
                end
            end
            if (hold_gap > 0) begin
                hold_gap--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(7) == 0) begin
                hold_gap = $urandom_range(16);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic cfg_write(logic [pidaw_pkg::CFG_IDX_W-1:0] idx,
                             logic [pidaw_pkg::DATA_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            pidaw_pkg::CFG_GAIN_P:     kp = longint'($signed(v));
            pidaw_pkg::CFG_GAIN_I:     ki = longint'($signed(v));
            pidaw_pkg::CFG_GAIN_D:     kd = longint'($signed(v));
            pidaw_pkg::CFG_LIMIT_LOW:  lim_lo = longint'($signed(v));
            pidaw_pkg::CFG_LIMIT_HIGH: lim_hi = longint'($signed(v));
            pidaw_pkg::CFG_TARGET:     setpoint = longint'($signed(v));
            default: ;
        endcase
    endtask

    // Wait until the block is idle and every result is back; sample away
    // from the rising edge so the driver's updates are already visible
    task automatic drain();
        do @(negedge aclk);
        while (step_queue.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
        endcase
    endfunction

    function automatic logic [31:0] pick_measure();
        case ($urandom_range(7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return 32'(setpoint) + 32'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
        endcase
    endfunction

    function automatic logic [31:0] pick_dt();
        case ($urandom_range(15))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            2: return $urandom;
            3: return 32'd1;
            default: return $urandom_range(1, 32'h20000);
        endcase
    endfunction

    function automatic pidaw_pkg::in_t rand_item();
        pidaw_pkg::in_t it;
        it.op = ($urandom_range(29) == 0) ? pidaw_pkg::OP_CLEAR : pidaw_pkg::OP_STEP;
        it.measured = pick_measure();
        it.step_time = pick_dt();
        return it;
    endfunction

    function automatic pidaw_pkg::in_t mk(logic op, logic [31:0] meas, logic [31:0] dt);
        pidaw_pkg::in_t it;
        it.op = op;
        it.measured = meas;
        it.step_time = dt;
        return it;
    endfunction

    initial begin
        int phases;
        logic [31:0] a, b;
        phases = 0;
        kp = 0; ki = 0; kd = 0; setpoint = 0;
        lim_lo = longint'(pidaw_pkg::LIMIT_LOW_RST);
        lim_hi = longint'(pidaw_pkg::LIMIT_HIGH_RST);
        integ = 0; prev_meas = 0; first_pt = 1'b1; clip_st = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset defaults, then moderate gains with tight limits
        step_queue.push_back(mk(pidaw_pkg::OP_STEP, 32'h0001_0000, 32'h0001_0000));
        drain();
        cfg_write(pidaw_pkg::CFG_GAIN_P, 32'h0002_0000);
        cfg_write(pidaw_pkg::CFG_GAIN_I, 32'h0000_8000);
        cfg_write(pidaw_pkg::CFG_GAIN_D, 32'h0000_4000);
        cfg_write(pidaw_pkg::CFG_LIMIT_LOW, 32'hfffa_0000);
        cfg_write(pidaw_pkg::CFG_LIMIT_HIGH, 32'h0006_0000);
        cfg_write(pidaw_pkg::CFG_TARGET, 32'h0003_0000);
        cfg_write(CFG_SPARE, 32'hdead_beef);
        step_queue.push_back(mk(pidaw_pkg::OP_STEP, 32'h0000_0000, 32'h0000_1000));
        step_queue.push_back(mk(pidaw_pkg::OP_STEP, 32'h0001_0000, 32'h0000_1000));
        step_queue.push_back(mk(pidaw_pkg::OP_STEP, 32'h0001_0000, 32'h0000_0000));
        step_queue.push_back(mk(pidaw_pkg::OP_STEP, 32'h7fff_ffff, 32'hffff_ffff));
        step_queue.push_back(mk(pidaw_pkg::OP_STEP, 32'h8000_0000, 32'h0000_0001));
        step_queue.push_back(mk(pidaw_pkg::OP_STEP, 32'h8000_0000, 32'hffff_ffff));
        step_queue.push_back(mk(pidaw_pkg::OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff));
        step_queue.push_back(mk(pidaw_pkg::OP_STEP, 32'hfff0_0000, 32'h0001_0000));
        for (int k = 0; k < 8; k++)
            step_queue.push_back(mk(pidaw_pkg::OP_STEP, 32'hfff0_0000, 32'h0004_0000));
        step_queue.push_back(mk(pidaw_pkg::OP_STEP, 32'h7fff_ffff, 32'h0000_0100));
        drain();
        // Crossed limits and extreme gains
        cfg_write(pidaw_pkg::CFG_LIMIT_LOW, 32'h0004_0000);
        cfg_write(pidaw_pkg::CFG_LIMIT_HIGH, 32'hfffc_0000);
        cfg_write(pidaw_pkg::CFG_GAIN_I, 32'h8000_0000);
        cfg_write(pidaw_pkg::CFG_GAIN_D, 32'h7fff_ffff);
        step_queue.push_back(mk(pidaw_pkg::OP_STEP, 32'h0000_0000, 32'h0001_0000));
        step_queue.push_back(mk(pidaw_pkg::OP_STEP, 32'h8000_0000, 32'h0000_0001));
        step_queue.push_back(mk(pidaw_pkg::OP_STEP, 32'h7fff_ffff, 32'h0000_0001));
        drain();

        // Random phases, each with a fresh configuration
        for (int ph = 0; ph < 8; ph++) begin
            a = $urandom;
            b = $urandom;
            cfg_write(pidaw_pkg::CFG_GAIN_P, pick_gain());
            cfg_write(pidaw_pkg::CFG_GAIN_I, (ph == 2) ? 32'd0 : pick_gain());
            cfg_write(pidaw_pkg::CFG_GAIN_D, pick_gain());
            if (ph == 5) begin
                cfg_write(pidaw_pkg::CFG_LIMIT_LOW, 32'h8000_0000);
                cfg_write(pidaw_pkg::CFG_LIMIT_HIGH, 32'h7fff_ffff);
            end else if (ph == 6) begin
                cfg_write(pidaw_pkg::CFG_LIMIT_LOW, a);
                cfg_write(pidaw_pkg::CFG_LIMIT_HIGH, b);
            end else begin
                a = $urandom_range(32'h10_0000, 32'h100);
                cfg_write(pidaw_pkg::CFG_LIMIT_LOW, -a);
                cfg_write(pidaw_pkg::CFG_LIMIT_HIGH, a + $urandom_range(32'h4_0000));
            end
            cfg_write(pidaw_pkg::CFG_TARGET, (ph == 4) ? $urandom : $urandom_range(0, 32'h40000));
            if (ph == 7) calm = 1'b1;
            for (int k = 0; k < 235; k++)
                step_queue.push_back(rand_item());
            drain();
            phases++;
        end

        $display("Covered %0d items in %0d random configurations plus directed cases.",
                 sent_count, phases);
        $display("Results seen: %0d, of which %0d clipped.", got_count, clip_count);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
